/* rtl/gevd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gevd_pkg: shared constants and types for the grid edge vertex dedup block
// Field widths, epoch tagging constants, back end states and helpers.
// ----------------------------------------------------------------------------
package gevd_pkg;

  localparam int GRID_SIZE_DEF = 16;
  localparam int NUM_AXES      = 3;

  localparam int COORD_W = 20;
  localparam int FRAC_W  = 16;
  localparam int INT_W   = COORD_W - FRAC_W;
  localparam int INDEX_W = 14;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_TUSER_W = 2;

  localparam logic [FRAC_W-1:0] THRESH_RESET = 16'd65;

  // Table entries carry an epoch tag; tag zero never matches a live epoch.
  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX   = 8'hFF;
  localparam logic [EPOCH_W-1:0] EPOCH_NONE  = 8'd0;

  localparam int QUEUE_DEPTH = 2;

  // Bit positions in out_tuser
  localparam int TUSER_IS_NEW = 0;
  localparam int TUSER_OOR    = 1;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } gevd_axis_t;

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_READ,
    S_LOOK
  } gevd_state_t;

  function automatic int table_depth(input int grid);
    return NUM_AXES * grid * grid * grid;
  endfunction

  function automatic int addr_width(input int grid);
    return $clog2(NUM_AXES * grid * grid * grid);
  endfunction

  // Queue item: {pos_z, pos_y, pos_x, addr, out_of_range, new_mesh}
  function automatic int item_width(input int grid);
    return 3 * COORD_W + $clog2(NUM_AXES * grid * grid * grid) + 2;
  endfunction

endpackage
`default_nettype wire

/* rtl/gevd_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gevd_front: input acceptance and vertex classification
// Holds the threshold register, picks the edge axis, range-checks the integer
// parts and forms the table address, then pushes the item to the queue.
// ----------------------------------------------------------------------------
module gevd_front #(
  parameter int GRID_SIZE = gevd_pkg::GRID_SIZE_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [gevd_pkg::FRAC_W-1:0]     cfg_wr_data,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [gevd_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic                            in_tuser,
  input  wire logic                            q_ready,
  input  wire logic                            sweeping,
  output logic                                 q_push,
  output logic [gevd_pkg::item_width(GRID_SIZE)-1:0] q_item
);

  localparam int CW     = gevd_pkg::COORD_W;
  localparam int FW     = gevd_pkg::FRAC_W;
  localparam int IW     = gevd_pkg::INT_W;
  localparam int ADDR_W = gevd_pkg::addr_width(GRID_SIZE);
  localparam int Vol    = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int Plane  = GRID_SIZE * GRID_SIZE;

  logic [FW-1:0]       thresh_r;
  logic [CW-1:0]       pos_x, pos_y, pos_z;
  logic [IW-1:0]       ix, iy, iz;
  logic                oor;
  gevd_pkg::gevd_axis_t axis;
  logic [ADDR_W-1:0]   addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= gevd_pkg::THRESH_RESET;
    end else if (cfg_wr_en) begin
      thresh_r <= cfg_wr_data;
    end
  end

  assign pos_x = in_tdata[CW-1:0];
  assign pos_y = in_tdata[2*CW-1:CW];
  assign pos_z = in_tdata[3*CW-1:2*CW];
  assign ix    = pos_x[CW-1:FW];
  assign iy    = pos_y[CW-1:FW];
  assign iz    = pos_z[CW-1:FW];

  always_comb begin
    oor = (int'(ix) >= GRID_SIZE) || (int'(iy) >= GRID_SIZE) || (int'(iz) >= GRID_SIZE);
    if (pos_y[FW-1:0] > thresh_r) begin
      axis = gevd_pkg::AXIS_Y;
    end else if (pos_z[FW-1:0] > thresh_r) begin
      axis = gevd_pkg::AXIS_Z;
    end else begin
      axis = gevd_pkg::AXIS_X;
    end
    addr = ADDR_W'(int'(axis) * Vol + int'(iz) * Plane + int'(iy) * GRID_SIZE + int'(ix));
  end

  // Hold off new vertices while the table is being swept
  assign in_tready = q_ready && !sweeping;
  assign q_push    = in_tvalid && in_tready;
  assign q_item    = {pos_z, pos_y, pos_x, addr, oor, in_tuser};

endmodule
`default_nettype wire

/* rtl/gevd_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gevd_queue: short FIFO between the classifier and the table engine
// Lets either side stall without holding up the other.
// ----------------------------------------------------------------------------
module gevd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = gevd_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  ready,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      head,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (int'(p) == DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  assign ready = (int'(count_r) != DEPTH);
  assign empty = (count_r == '0);
  assign head  = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= DEPTH)
    else $error("queue occupancy beyond depth");

endmodule
`default_nettype wire

/* rtl/gevd_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gevd_back: slot table engine
// Epoch-tagged slot memory, index allocation, clearing sweep and the result
// register.
// ----------------------------------------------------------------------------
module gevd_back #(
  parameter int GRID_SIZE = gevd_pkg::GRID_SIZE_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic [gevd_pkg::item_width(GRID_SIZE)-1:0] q_head,
  input  wire logic                             q_empty,
  output logic                                  q_pop,
  output logic                                  sweeping,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [gevd_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic [gevd_pkg::OUT_TUSER_W-1:0]      out_tuser
);

  localparam int CW     = gevd_pkg::COORD_W;
  localparam int XW     = gevd_pkg::INDEX_W;
  localparam int EW     = gevd_pkg::EPOCH_W;
  localparam int ADDR_W = gevd_pkg::addr_width(GRID_SIZE);
  localparam int Depth  = gevd_pkg::table_depth(GRID_SIZE);
  localparam int PadW   = gevd_pkg::OUT_TDATA_W - 3 * CW - XW;

  // Slot memory: {epoch tag, index}
  logic [EW+XW-1:0] mem [Depth];
  logic [EW+XW-1:0] rd_data_r;
  logic             mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [EW+XW-1:0] mem_wdata;

  gevd_pkg::gevd_state_t state_r, state_nxt;
  logic [EW-1:0]     epoch_r, epoch_nxt;
  logic [XW-1:0]     next_free_r, next_free_nxt;
  logic [ADDR_W-1:0] sweep_cnt_r, sweep_cnt_nxt;
  logic              resume_r, resume_nxt;

  // Work item
  logic              work_oor_r, work_oor_nxt;
  logic [ADDR_W-1:0] work_addr_r, work_addr_nxt;
  logic [CW-1:0]     work_x_r, work_x_nxt, work_y_r, work_y_nxt, work_z_r, work_z_nxt;

  // Result register
  logic          out_valid_r, out_valid_nxt;
  logic [XW-1:0] res_index_r, res_index_nxt;
  logic          res_new_r, res_new_nxt, res_oor_r, res_oor_nxt;
  logic [CW-1:0] res_x_r, res_x_nxt, res_y_r, res_y_nxt, res_z_r, res_z_nxt;

  logic              head_new_mesh, head_oor;
  logic [ADDR_W-1:0] head_addr;
  logic [CW-1:0]     head_x, head_y, head_z;
  logic              out_free, hit, alloc;

  assign head_new_mesh = q_head[0];
  assign head_oor      = q_head[1];
  assign head_addr     = q_head[ADDR_W+1:2];
  assign head_x        = q_head[ADDR_W+2+CW-1:ADDR_W+2];
  assign head_y        = q_head[ADDR_W+2+2*CW-1:ADDR_W+2+CW];
  assign head_z        = q_head[ADDR_W+2+3*CW-1:ADDR_W+2+2*CW];

  assign out_free = !out_valid_r || out_tready;
  assign hit      = (rd_data_r[EW+XW-1:XW] == epoch_r);
  assign alloc    = (state_r == gevd_pkg::S_LOOK) && out_free && !work_oor_r && !hit;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gevd_pkg::S_SWEEP;
      epoch_r     <= gevd_pkg::EPOCH_FIRST;
      next_free_r <= '0;
      sweep_cnt_r <= '0;
      resume_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      epoch_r     <= epoch_nxt;
      next_free_r <= next_free_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      resume_r    <= resume_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_oor_r  <= work_oor_nxt;
    work_addr_r <= work_addr_nxt;
    work_x_r    <= work_x_nxt;
    work_y_r    <= work_y_nxt;
    work_z_r    <= work_z_nxt;
    res_index_r <= res_index_nxt;
    res_new_r   <= res_new_nxt;
    res_oor_r   <= res_oor_nxt;
    res_x_r     <= res_x_nxt;
    res_y_r     <= res_y_nxt;
    res_z_r     <= res_z_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    epoch_nxt     = epoch_r;
    next_free_nxt = next_free_r;
    sweep_cnt_nxt = sweep_cnt_r;
    resume_nxt    = resume_r;
    work_oor_nxt  = work_oor_r;
    work_addr_nxt = work_addr_r;
    work_x_nxt    = work_x_r;
    work_y_nxt    = work_y_r;
    work_z_nxt    = work_z_r;
    out_valid_nxt = out_valid_r && !out_tready;
    res_index_nxt = res_index_r;
    res_new_nxt   = res_new_r;
    res_oor_nxt   = res_oor_r;
    res_x_nxt     = res_x_r;
    res_y_nxt     = res_y_r;
    res_z_nxt     = res_z_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = work_addr_r;
    mem_wdata     = {epoch_r, next_free_r};
    mem_re        = 1'b0;
    mem_raddr     = work_addr_r;

    unique case (state_r)
      gevd_pkg::S_SWEEP: begin
        mem_we        = 1'b1;
        mem_waddr     = sweep_cnt_r;
        mem_wdata     = {gevd_pkg::EPOCH_NONE, XW'(0)};
        sweep_cnt_nxt = sweep_cnt_r + 1'b1;
        if (int'(sweep_cnt_r) == Depth - 1) begin
          sweep_cnt_nxt = '0;
          state_nxt     = resume_r ? gevd_pkg::S_READ : gevd_pkg::S_IDLE;
        end
      end
      gevd_pkg::S_IDLE: begin
        if (!q_empty) begin
          q_pop         = 1'b1;
          mem_re        = 1'b1;
          mem_raddr     = head_addr;
          work_oor_nxt  = head_oor;
          work_addr_nxt = head_addr;
          work_x_nxt    = head_x;
          work_y_nxt    = head_y;
          work_z_nxt    = head_z;
          state_nxt     = gevd_pkg::S_LOOK;
          if (head_new_mesh) begin
            next_free_nxt = '0;
            if (epoch_r == gevd_pkg::EPOCH_MAX) begin
              // Tags would wrap: wipe the table, then restart at the first epoch
              epoch_nxt  = gevd_pkg::EPOCH_FIRST;
              resume_nxt = 1'b1;
              state_nxt  = gevd_pkg::S_SWEEP;
            end else begin
              epoch_nxt = epoch_r + 1'b1;
            end
          end
        end
      end
      gevd_pkg::S_READ: begin
        mem_re     = 1'b1;
        resume_nxt = 1'b0;
        state_nxt  = gevd_pkg::S_LOOK;
      end
      gevd_pkg::S_LOOK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          res_oor_nxt   = work_oor_r;
          res_new_nxt   = 1'b0;
          res_index_nxt = '0;
          res_x_nxt     = '0;
          res_y_nxt     = '0;
          res_z_nxt     = '0;
          if (!work_oor_r) begin
            if (hit) begin
              res_index_nxt = rd_data_r[XW-1:0];
            end else begin
              mem_we        = 1'b1;
              next_free_nxt = next_free_r + 1'b1;
              res_index_nxt = next_free_r;
              res_new_nxt   = 1'b1;
              res_x_nxt     = work_x_r;
              res_y_nxt     = work_y_r;
              res_z_nxt     = work_z_r;
            end
          end
          state_nxt = gevd_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = gevd_pkg::S_IDLE;
      end
    endcase
  end

  assign sweeping   = (state_r == gevd_pkg::S_SWEEP);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {PadW'(0), res_z_r, res_y_r, res_x_r, res_index_r};
  assign out_tuser  = {res_oor_r, res_new_r};

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_new_r && res_oor_r))
    else $error("result marked both new and out of range");

  a_alloc_advances: assert property (@(posedge clk) disable iff (!rst_n)
    alloc |=> (next_free_r == $past(next_free_r) + 1'b1))
    else $error("allocation did not advance the free index");

  a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
    epoch_r != gevd_pkg::EPOCH_NONE)
    else $error("live epoch equals the cleared tag");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gevd_pkg::S_SWEEP) |-> (!q_pop && !mem_re))
    else $error("table access during clearing sweep");

endmodule
`default_nettype wire

/* rtl/grid_edge_vertex_dedup_top.sv */
`default_nettype none
// Path: an accepted vertex goes through the queue, the table read and then
//   lookup/allocate into the result register, once that register is free.
// Flow: the table engine takes one vertex at a time, reading its slot in the
//   IDLE state and checking or allocating it in LOOK; a 2-entry queue
//   decouples input from the table engine.
// Reset (synchronous, rst_n low): threshold to 65, numbering to zero, then a
//   clearing pass over all 3*GRID_SIZE^3 slots with in_tready low; every 255th
//   new_mesh vertex triggers the same pass before it is handled.
// ----------------------------------------------------------------------------
// grid_edge_vertex_dedup_top: vertex welding on grid edges
// Classifies each vertex by edge axis and grid cell, looks its slot up in an
// epoch-tagged table and returns a shared or freshly allocated index.
// ----------------------------------------------------------------------------
module grid_edge_vertex_dedup_top #(
  parameter int GRID_SIZE = gevd_pkg::GRID_SIZE_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Threshold register write
  input  wire logic                             cfg_wr_en,
  input  wire logic [gevd_pkg::FRAC_W-1:0]      cfg_wr_data,
  // Vertex input. tdata: pos_x[19:0], pos_y[39:20], pos_z[59:40], zero pad
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [gevd_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                             in_tuser,    // new_mesh
  // Result. tdata: vertex_index[13:0], new_x[33:14], new_y[53:34],
  //   new_z[73:54], zero pad
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [gevd_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic [gevd_pkg::OUT_TUSER_W-1:0]      out_tuser    // is_new, out_of_range
);

  localparam int ItemW = gevd_pkg::item_width(GRID_SIZE);

  // Classified vertex travelling from the front end to the table engine
  logic             q_push, q_ready, q_pop, q_empty;
  logic [ItemW-1:0] q_item, q_head;
  // Engine is wiping the table: hold the input side
  logic             sweeping;

  gevd_front #(
    .GRID_SIZE (GRID_SIZE)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .q_ready     (q_ready),
    .sweeping    (sweeping),
    .q_push      (q_push),
    .q_item      (q_item)
  );

  // Short queue: front keeps taking vertices while the engine works one through
  gevd_queue #(
    .WIDTH (ItemW),
    .DEPTH (gevd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_item),
    .ready     (q_ready),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // Table engine: one lookup and optional allocation per vertex, result register
  // at its output so a stalled consumer does not block the queue filling
  gevd_back #(
    .GRID_SIZE (GRID_SIZE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .sweeping   (sweeping),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

/* bench/grid_edge_vertex_dedup_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_edge_vertex_dedup_top_test: self-checking bench for vertex welding
// Streams mesh vertices into the block and predicts, for each accepted
// vertex, the edge axis, the table slot and the shared or freshly allocated
// index. Every result transaction is checked field by field against the
// oldest prediction. Covers coordinate and threshold extremes, back-to-back
// mesh starts, random meshes with repeats, enough mesh starts to wrap the
// epoch tag, a long output hold-off and a sender pause, under three idling
// mixes.
// ----------------------------------------------------------------------------
module grid_edge_vertex_dedup_top_test;
  import gevd_pkg::*;

  localparam int GRID = GRID_SIZE_DEF;
  // Longest quiet spell: a clearing pass of the whole table, with margin.
  localparam int WATCHDOG_LIMIT = 3 * NUM_AXES * GRID * GRID * GRID + 2000;
  localparam int HISTORY_DEPTH = 64;
  localparam int MISMATCH_PRINT_CAP = 50;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [INDEX_W-1:0] vertex_index;
    logic               is_new;
    logic               out_of_range;
    coord_t             new_x;
    coord_t             new_y;
    coord_t             new_z;
  } weld_result_t;

  // Block ports, all inputs at known values from time zero
  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [FRAC_W-1:0]      cfg_wr_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  // Predictor state: occupied slots and their indexes, numbering, threshold
  logic [INDEX_W-1:0] cell_index [int unsigned];
  logic [INDEX_W-1:0] next_index = '0;
  logic [FRAC_W-1:0]  edge_threshold = THRESH_RESET;

  weld_result_t             pending_welds [$];
  logic [3*COORD_W-1:0]     mesh_history [$];

  int send_gap_pct = 36;
  int recv_gap_pct = 50;
  int hold_off_request = 0;
  int hold_off_left = 0;
  int meshes_started = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  grid_edge_vertex_dedup_top #(
    .GRID_SIZE(GRID)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor: weld one vertex into the table copy and return its result
  // --------------------------------------------------------------------------
  function automatic weld_result_t weld_vertex(input logic new_mesh, input coord_t px,
                                               input coord_t py, input coord_t pz);
    weld_result_t res;
    int unsigned  ix;
    int unsigned  iy;
    int unsigned  iz;
    int unsigned  slot;
    gevd_axis_t   axis;
    res = '0;
    // A mesh start empties the table even if the vertex itself is rejected
    if (new_mesh) begin
      cell_index.delete();
      next_index = '0;
    end
    ix = px[COORD_W-1:FRAC_W];
    iy = py[COORD_W-1:FRAC_W];
    iz = pz[COORD_W-1:FRAC_W];
    if (ix >= GRID || iy >= GRID || iz >= GRID) begin
      res.out_of_range = 1'b1;
      return res;
    end
    // y wins over z; the x fraction never selects an axis
    if (py[FRAC_W-1:0] > edge_threshold)
      axis = AXIS_Y;
    else if (pz[FRAC_W-1:0] > edge_threshold)
      axis = AXIS_Z;
    else
      axis = AXIS_X;
    slot = int'(axis) * GRID * GRID * GRID + (iz * GRID + iy) * GRID + ix;
    if (cell_index.exists(slot)) begin
      res.vertex_index = cell_index[slot];
    end else begin
      cell_index[slot] = next_index;
      res.vertex_index = next_index;
      res.is_new = 1'b1;
      res.new_x = px;
      res.new_y = py;
      res.new_z = pz;
      next_index = next_index + 1'b1;
    end
    return res;
  endfunction

  function automatic coord_t to_fixed(input int unsigned int_part, input int unsigned frac);
    return {int_part[INT_W-1:0], frac[FRAC_W-1:0]};
  endfunction

  // Fractions cluster round the threshold so both sides of the compare get hit
  function automatic logic [FRAC_W-1:0] pick_fraction();
    case ($urandom_range(5))
      0: return '0;
      1: return edge_threshold;
      2: return (edge_threshold == '1) ? edge_threshold : edge_threshold + 1'b1;
      3: return '1;
      4: return $urandom_range(edge_threshold);
      default: return $urandom();
    endcase
  endfunction

  // Mostly small cells for collisions; now and then the whole integer field
  function automatic logic [INT_W-1:0] pick_int_part();
    if ($urandom_range(9) == 0)
      return $urandom_range((1 << INT_W) - 1);
    if ($urandom_range(1) == 0)
      return $urandom_range(3);
    return $urandom_range(GRID - 1);
  endfunction

  // --------------------------------------------------------------------------
  // Shared driving, reporting and checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    // Keep the log short if the block goes badly wrong; still count all
    if (mismatch_count < MISMATCH_PRINT_CAP)
      $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic compare_field(input string field, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s is %0h, expected %0h",
                                results_checked, field, got, want));
  endtask

  // Offer one vertex, hold it until the block takes it, then predict
  task automatic send_vertex(input logic new_mesh, input coord_t px, input coord_t py,
                             input coord_t pz);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= new_mesh;
    in_tdata  <= {{(IN_TDATA_W - 3 * COORD_W){1'b0}}, pz, py, px};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (new_mesh)
      meshes_started++;
    pending_welds.insert(pending_welds.size(), weld_vertex(new_mesh, px, py, pz));
  endtask

  // Drop valid and hold until every predicted result has been taken
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_welds.size() != 0) @(posedge clk);
  endtask

  // Only called with nothing in flight, so the new threshold applies cleanly
  task automatic write_threshold(input logic [FRAC_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    edge_threshold = value;
  endtask

  // Build a mesh vertex: an exact repeat, the same cell with new fractions,
  // or a fresh point. A mesh start forgets the history.
  task automatic send_random_mesh_vertex(input int new_mesh_pct);
    logic                 new_mesh;
    coord_t               px;
    coord_t               py;
    coord_t               pz;
    int                   pick;
    new_mesh = ($urandom_range(99) < new_mesh_pct);
    if (new_mesh)
      mesh_history.delete();
    pick = $urandom_range(99);
    if (mesh_history.size() != 0 && pick < 55) begin
      {pz, py, px} = mesh_history[$urandom_range(mesh_history.size() - 1)];
      if (pick >= 35) begin
        px[FRAC_W-1:0] = pick_fraction();
        py[FRAC_W-1:0] = pick_fraction();
        pz[FRAC_W-1:0] = pick_fraction();
      end
    end else begin
      px = {pick_int_part(), pick_fraction()};
      py = {pick_int_part(), pick_fraction()};
      pz = {pick_int_part(), pick_fraction()};
    end
    mesh_history.insert(mesh_history.size(), {pz, py, px});
    if (mesh_history.size() > HISTORY_DEPTH)
      void'(mesh_history.pop_front());
    send_vertex(new_mesh, px, py, pz);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset threshold, grid corners, axis priority and table emptying
  task automatic test_directed_vertices();
    send_vertex(1'b1, to_fixed(0, 0), to_fixed(0, 0), to_fixed(0, 0));
    send_vertex(1'b0, to_fixed(0, 0), to_fixed(0, 0), to_fixed(0, 0));
    send_vertex(1'b0, '1, '1, '1);
    // y exactly at threshold does not count, z one above does
    send_vertex(1'b0, to_fixed(3, 0), to_fixed(3, 65), to_fixed(3, 66));
    send_vertex(1'b0, to_fixed(3, 0), to_fixed(3, 66), to_fixed(3, 66));
    // x fraction plays no part: same slot as the z-axis vertex above
    send_vertex(1'b0, to_fixed(3, 'hFFFF), to_fixed(3, 65), to_fixed(3, 66));
    send_vertex(1'b0, to_fixed(7, 'hFFFF), to_fixed(7, 65), to_fixed(7, 65));
    send_vertex(1'b0, to_fixed(GRID - 1, 0), to_fixed(0, 0), to_fixed(0, 0));
    send_vertex(1'b0, to_fixed(0, 0), to_fixed(GRID - 1, 0), to_fixed(0, 0));
    send_vertex(1'b0, to_fixed(0, 0), to_fixed(0, 0), to_fixed(GRID - 1, 0));
    send_vertex(1'b0, '1, '1, '1);
    // New mesh: numbering restarts and old slots are gone
    send_vertex(1'b1, to_fixed(0, 0), to_fixed(0, 0), to_fixed(0, 0));
    send_vertex(1'b0, '1, '1, '1);
    send_vertex(1'b1, '1, '1, '1);
    send_vertex(1'b1, '1, '1, '1);
    wait_for_results();
  endtask

  // Threshold of zero: any nonzero fraction marks; all ones: nothing marks
  task automatic test_threshold_extremes();
    write_threshold('0);
    send_vertex(1'b0, to_fixed(1, 0), to_fixed(2, 0), to_fixed(3, 0));
    send_vertex(1'b0, to_fixed(1, 0), to_fixed(2, 1), to_fixed(3, 0));
    send_vertex(1'b0, to_fixed(1, 0), to_fixed(2, 0), to_fixed(3, 1));
    wait_for_results();
    write_threshold('1);
    send_vertex(1'b0, to_fixed(5, 'hFFFF), to_fixed(5, 'hFFFF), to_fixed(5, 'hFFFF));
    send_vertex(1'b0, to_fixed(5, 0), to_fixed(5, 0), to_fixed(5, 0));
    wait_for_results();
  endtask

  // Random meshes of a few dozen vertices with repeats, under one threshold
  task automatic test_random_meshes(input int count, input logic [FRAC_W-1:0] threshold);
    write_threshold(threshold);
    repeat (count) send_random_mesh_vertex(3);
    wait_for_results();
  endtask

  // Short meshes until the epoch tag has wrapped and the table was swept
  task automatic test_mesh_rollover();
    while (meshes_started < 300) send_random_mesh_vertex(85);
    // Longer meshes after the sweep: stale slots must not come back
    repeat (30) send_random_mesh_vertex(5);
    wait_for_results();
  endtask

  // Receiver holds off while the sender keeps offering: the block fills up
  task automatic test_output_backpressure();
    hold_off_request = 200;
    repeat (40) send_random_mesh_vertex(3);
    wait_for_results();
  endtask

  // Sender stops mid-mesh until everything has drained, then carries on
  task automatic test_sender_pause();
    repeat (20) send_random_mesh_vertex(0);
    wait_for_results();
    repeat (20) send_random_mesh_vertex(0);
    wait_for_results();
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random ready, or a long hold-off counted here
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_off_request != 0) begin
      hold_off_left = hold_off_request;
      hold_off_request = 0;
    end
    if (hold_off_left != 0) begin
      hold_off_left = hold_off_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Check every result transaction against the oldest prediction
  always @(posedge clk) begin : check_result
    weld_result_t want;
    weld_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.vertex_index = out_tdata[INDEX_W-1:0];
      got.new_x        = out_tdata[INDEX_W +: COORD_W];
      got.new_y        = out_tdata[INDEX_W + COORD_W +: COORD_W];
      got.new_z        = out_tdata[INDEX_W + 2 * COORD_W +: COORD_W];
      got.is_new       = out_tuser[TUSER_IS_NEW];
      got.out_of_range = out_tuser[TUSER_OOR];
      if (pending_welds.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected",
                                  results_checked));
      end else begin
        want = pending_welds.pop_front();
        compare_field("vertex_index", got.vertex_index, want.vertex_index);
        compare_field("is_new", got.is_new, want.is_new);
        compare_field("out_of_range", got.out_of_range, want.out_of_range);
        compare_field("new_x", got.new_x, want.new_x);
        compare_field("new_y", got.new_y, want.new_y);
        compare_field("new_z", got.new_z, want.new_z);
      end
      results_checked++;
    end
  end

  // Watchdog: end the run if no transaction moves on either side for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset once, then the tests under the three idling mixes
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Sender idles 36 %, receiver 50 %
    test_directed_vertices();
    test_threshold_extremes();
    test_random_meshes(90, $urandom());

    // Swap the idling
    send_gap_pct = 50;
    recv_gap_pct = 36;
    test_random_meshes(90, THRESH_RESET);
    test_mesh_rollover();

    // No idling on either side
    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_output_backpressure();
    test_sender_pause();
    test_random_meshes(90, $urandom_range(0, 300));

    wait_for_results();
    repeat (8) @(posedge clk);
    if (pending_welds.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_welds.size()));
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
